// ===== hw/rtl/ego_pkg.sv =====
`default_nettype none
// ============================================================================
// ego_pkg
// Shared types, constants and table for the encoder and gyro odometry block.
// ============================================================================
package ego_pkg;

    localparam int ACC_FRAC_BITS_DEF  = 16;
    localparam int TRIG_FRAC_BITS_DEF = 15;

    localparam logic [1:0] CFG_OFFSET_X = 2'd0;
    localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
    localparam logic [1:0] CFG_INVERT_X = 2'd2;
    localparam logic [1:0] CFG_INVERT_Y = 2'd3;

    localparam logic signed [15:0] OFFSET_X_RST = -16'sd344;
    localparam logic signed [15:0] OFFSET_Y_RST = 16'sd1238;

    // pi / 1800 in Q0.32.
    localparam logic [22:0] PI_OVER_1800_Q32 = 23'd7496132;

    localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

    typedef struct packed {
        logic               command;
        logic signed [31:0] encoder_x;
        logic signed [31:0] encoder_y;
        logic signed [15:0] gyro_tenths;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [11:0] heading_tenths;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic       wrap;
        logic       prep;
        logic       trig;
        logic       calc;
        logic [3:0] step;
        logic       store;
    } t_cmd;

    typedef struct packed {
        logic head_ok;
        logic is_clear;
        logic out_free;
    } t_sts;

    localparam logic [15:0] SINE_Q15 [0:90] = '{
        16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
        16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927,
        16'd8481, 16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743,
        16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384,
        16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795,
        16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926,
        16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166,
        16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197,
        16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792,
        16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928,
        16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
    };

    function automatic logic [15:0] sine_q15(input logic [6:0] idx);
        logic [15:0] v;
        v = 16'd0;
        if (idx <= 7'd90) begin
            v = SINE_Q15[idx];
        end
        return v;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [67:0] v);
        logic signed [47:0] r;
        if (v > 68'(ACC_MAX)) begin
            r = ACC_MAX;
        end else if (v < 68'(ACC_MIN)) begin
            r = ACC_MIN;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/encoder_gyro_odometry.sv =====
`default_nettype none
// An update beat runs from acceptance through the wrap state, which repeats once for
// each extra turn of heading wrap, then prep, trig, the 16 calc steps and done, where
// it waits until the output register is free; a clear beat goes straight to done.
// One beat at a time: the 16 steps share one 29x25 multiplier, and a new beat is taken
// while a finished result waits in the output register.
// Reset is synchronous, active low; it restores defaults.
// ============================================================================
// encoder_gyro_odometry
// Dead-reckoning odometry from two tracking-wheel encoders and a gyro heading.
// ============================================================================
module encoder_gyro_odometry #(
    parameter int ACC_FRAC_BITS  = ego_pkg::ACC_FRAC_BITS_DEF,
    parameter int TRIG_FRAC_BITS = ego_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [15:0]       i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire ego_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output ego_pkg::t_out_item     o_out_data
);

    ego_pkg::t_cmd cmd;
    ego_pkg::t_sts sts;

    ego_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (o_in_stall)
    );

    ego_dp #(
        .ACC_FRAC_BITS  (ACC_FRAC_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/ego_ctrl.sv =====
`default_nettype none
// ============================================================================
// ego_ctrl
// Sequencer: accepts a beat, steps the datapath, hands the result over.
// ============================================================================
module ego_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire ego_pkg::t_sts i_sts,
    output ego_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_PREP,
        ST_TRIG,
        ST_CALC,
        ST_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.step = r_step;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = i_sts.is_clear ? ST_DONE : ST_WRAP;
                end
            end
            ST_WRAP: begin
                o_cmd.wrap = 1'b1;
                if (i_sts.head_ok) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_TRIG;
            end
            ST_TRIG: begin
                o_cmd.trig = 1'b1;
                n_state    = ST_CALC;
                n_step     = '0;
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_step     = r_step + 4'd1;
                if (r_step == 4'd15) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.store = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/ego_dp.sv =====
`default_nettype none
// ============================================================================
// ego_dp
// Datapath: heading wrap, offset correction, rotation, accumulation, scaling.
// ============================================================================
module ego_dp #(
    parameter int ACC_FRAC_BITS  = ego_pkg::ACC_FRAC_BITS_DEF,
    parameter int TRIG_FRAC_BITS = ego_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [15:0]       i_cfg_data,
    input  wire ego_pkg::t_in_item i_in_data,
    input  wire logic              i_out_stall,
    input  wire ego_pkg::t_cmd     i_cmd,
    output ego_pkg::t_sts          o_sts,
    output logic                   o_out_valid,
    output ego_pkg::t_out_item     o_out_data
);

    localparam int CORR_SH = 32 - ACC_FRAC_BITS;
    localparam int TRIG_SH = 15 - TRIG_FRAC_BITS;
    localparam logic [16:0] TRIG_RND = 17'((1 << TRIG_SH) >> 1);
    localparam logic signed [57:0] CORR_RND = 58'((64'd1 << CORR_SH) >> 1);
    localparam logic signed [67:0] ACC_RND = 68'(1) <<< (TRIG_FRAC_BITS - 1);

    logic signed [15:0] r_off_x, r_off_y;
    logic               r_inv_x, r_inv_y;
    logic [31:0]        r_ex, r_ey, r_prev_ex, r_prev_ey;
    logic signed [16:0] r_head;
    logic signed [11:0] r_prev_head, r_da;
    logic signed [31:0] r_dx, r_dy;
    logic [7:0]         r_deg;
    logic               r_deg_neg;
    logic signed [16:0] r_sin, r_cos;
    logic signed [53:0] r_prod;
    logic signed [47:0] r_cx, r_cy, r_acc_x, r_acc_y;
    logic signed [66:0] r_sum;
    logic [17:0]        r_mag_x, r_mag_y;
    logic               r_neg_x, r_neg_y;
    logic signed [15:0] r_pos_x, r_pos_y;
    logic               r_out_valid;
    ego_pkg::t_out_item r_out;

    logic               head_ok;
    logic signed [12:0] diff, da_w;
    logic signed [11:0] h12, habs;
    logic [23:0]        deg_prod;
    logic [6:0]         sidx, cidx;
    logic [16:0]        s_val, c_val;
    logic signed [28:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [53:0] mul_p;
    logic signed [31:0] d_sel;
    logic signed [57:0] prod_rnd, d_sh;
    logic signed [47:0] corr;
    logic signed [66:0] p_ext, p_hi;
    logic signed [47:0] acc_in, acc_new;
    logic signed [49:0] t3x, t3y;
    logic [49:0]        mx, my;
    logic [17:0]        cx_mag, cy_mag;
    logic [34:0]        qx_p, qy_p;
    logic [16:0]        qx, qy;
    logic signed [15:0] px, py;

    assign head_ok = (r_head <= 17'sd1800) && (r_head >= -17'sd1800);

    // Heading change is at most one turn away, so a single correction suffices.
    always_comb begin
        diff = 13'(r_head) - 13'(r_prev_head);
        da_w = diff;
        if (diff > 13'sd1800) begin
            da_w = diff - 13'sd3600;
        end else if (diff < -13'sd1800) begin
            da_w = diff + 13'sd3600;
        end
    end

    // Whole degrees by multiplying with 2^16 / 10; exact over the heading range.
    assign h12      = r_head[11:0];
    assign habs     = (h12 < 0) ? -h12 : h12;
    assign deg_prod = 24'(habs[10:0]) * 24'd6554;

    always_comb begin
        if (r_deg <= 8'd90) begin
            sidx = r_deg[6:0];
            cidx = 7'(8'd90 - r_deg);
        end else begin
            sidx = 7'(8'd180 - r_deg);
            cidx = 7'(r_deg - 8'd90);
        end
        s_val = ({1'b0, ego_pkg::sine_q15(sidx)} + TRIG_RND) >> TRIG_SH;
        c_val = ({1'b0, ego_pkg::sine_q15(cidx)} + TRIG_RND) >> TRIG_SH;
    end

    // Shared multiplier; wide operands are split into 24-bit halves.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.step)
            4'd0: begin
                mul_a = 29'(r_off_y);
                mul_b = 25'(r_da);
            end
            4'd1, 4'd3: begin
                mul_a = r_prod[28:0];
                mul_b = 25'({1'b0, ego_pkg::PI_OVER_1800_Q32});
            end
            4'd2: begin
                mul_a = 29'(r_off_x);
                mul_b = 25'(r_da);
            end
            4'd4: begin
                mul_a = {5'd0, r_cx[23:0]};
                mul_b = 25'(r_cos);
            end
            4'd5: begin
                mul_a = 29'($signed(r_cx[47:24]));
                mul_b = 25'(r_cos);
            end
            4'd6: begin
                mul_a = {5'd0, r_cy[23:0]};
                mul_b = 25'(r_sin);
            end
            4'd7: begin
                mul_a = 29'($signed(r_cy[47:24]));
                mul_b = 25'(r_sin);
            end
            4'd8: begin
                mul_a = {5'd0, r_cy[23:0]};
                mul_b = 25'(r_cos);
            end
            4'd9: begin
                mul_a = 29'($signed(r_cy[47:24]));
                mul_b = 25'(r_cos);
            end
            4'd10: begin
                mul_a = {5'd0, r_cx[23:0]};
                mul_b = 25'(r_sin);
            end
            4'd11: begin
                mul_a = 29'($signed(r_cx[47:24]));
                mul_b = 25'(r_sin);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 54'(mul_a) * 54'(mul_b);

    assign d_sel    = (i_cmd.step == 4'd2) ? r_dx : r_dy;
    assign prod_rnd = (58'(r_prod) + CORR_RND) >>> CORR_SH;
    assign d_sh     = 58'(d_sel) <<< ACC_FRAC_BITS;
    assign corr     = ego_pkg::sat48(68'(d_sh - prod_rnd));

    assign p_ext   = 67'(r_prod);
    assign p_hi    = p_ext <<< 24;
    assign acc_in  = (i_cmd.step == 4'd9) ? r_acc_x : r_acc_y;
    assign acc_new = ego_pkg::sat48(68'(acc_in) + ((68'(r_sum) + ACC_RND) >>> TRIG_FRAC_BITS));

    // Output scale 3 / (20 * 2^F): take magnitude, shift by F + 2, divide by 5.
    assign t3x = (50'(r_acc_x) <<< 1) + 50'(r_acc_x);
    assign t3y = (50'(r_acc_y) <<< 1) + 50'(r_acc_y);
    assign mx  = 50'((t3x < 0) ? -t3x : t3x) >> (ACC_FRAC_BITS + 2);
    assign my  = 50'((t3y < 0) ? -t3y : t3y) >> (ACC_FRAC_BITS + 2);
    assign cx_mag = (mx >= 50'd163840) ? 18'd163840 : mx[17:0];
    assign cy_mag = (my >= 50'd163840) ? 18'd163840 : my[17:0];
    assign qx_p = 35'(r_mag_x) * 35'd52429;
    assign qy_p = 35'(r_mag_y) * 35'd52429;
    assign qx   = qx_p[34:18];
    assign qy   = qy_p[34:18];
    assign px   = r_neg_x ? 16'(-$signed({1'b0, qx})) :
                  ((qx > 17'd32767) ? 16'sd32767 : $signed(qx[15:0]));
    assign py   = r_neg_y ? 16'(-$signed({1'b0, qy})) :
                  ((qy > 17'd32767) ? 16'sd32767 : $signed(qy[15:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x     <= ego_pkg::OFFSET_X_RST;
            r_off_y     <= ego_pkg::OFFSET_Y_RST;
            r_inv_x     <= 1'b0;
            r_inv_y     <= 1'b0;
            r_prev_ex   <= '0;
            r_prev_ey   <= '0;
            r_prev_head <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ego_pkg::CFG_OFFSET_X: r_off_x <= $signed(i_cfg_data);
                    ego_pkg::CFG_OFFSET_Y: r_off_y <= $signed(i_cfg_data);
                    ego_pkg::CFG_INVERT_X: r_inv_x <= i_cfg_data[0];
                    ego_pkg::CFG_INVERT_Y: r_inv_y <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.load) begin
                if (i_in_data.command) begin
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                    r_pos_x <= '0;
                    r_pos_y <= '0;
                end else begin
                    r_ex   <= r_inv_x ? -i_in_data.encoder_x : i_in_data.encoder_x;
                    r_ey   <= r_inv_y ? -i_in_data.encoder_y : i_in_data.encoder_y;
                    r_head <= 17'(i_in_data.gyro_tenths);
                end
            end

            if (i_cmd.wrap) begin
                if (r_head > 17'sd1800) begin
                    r_head <= r_head - 17'sd3600;
                end else if (r_head < -17'sd1800) begin
                    r_head <= r_head + 17'sd3600;
                end
            end

            if (i_cmd.prep) begin
                r_dx        <= $signed(r_ex - r_prev_ex);
                r_dy        <= $signed(r_ey - r_prev_ey);
                r_prev_ex   <= r_ex;
                r_prev_ey   <= r_ey;
                r_da        <= da_w[11:0];
                r_prev_head <= h12;
                r_deg       <= deg_prod[23:16];
                r_deg_neg   <= (h12 < 0);
            end

            if (i_cmd.trig) begin
                r_sin <= r_deg_neg ? -$signed(s_val) : $signed(s_val);
                r_cos <= (r_deg > 8'd90) ? -$signed(c_val) : $signed(c_val);
            end

            if (i_cmd.calc) begin
                r_prod <= mul_p;
                case (i_cmd.step)
                    4'd2:  r_cx  <= corr;
                    4'd4:  r_cy  <= corr;
                    4'd5:  r_sum <= p_ext;
                    4'd6:  r_sum <= r_sum + p_hi;
                    4'd7:  r_sum <= r_sum - p_ext;
                    4'd8:  r_sum <= r_sum - p_hi;
                    4'd9: begin
                        r_acc_x <= acc_new;
                        r_sum   <= p_ext;
                    end
                    4'd10: r_sum <= r_sum + p_hi;
                    4'd11: r_sum <= r_sum + p_ext;
                    4'd12: r_sum <= r_sum + p_hi;
                    4'd13: r_acc_y <= acc_new;
                    4'd14: begin
                        r_mag_x <= cx_mag;
                        r_mag_y <= cy_mag;
                        r_neg_x <= r_acc_x < 0;
                        r_neg_y <= r_acc_y < 0;
                    end
                    4'd15: begin
                        r_pos_x <= px;
                        r_pos_y <= py;
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.store) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.store) begin
            r_out.pos_x          <= r_pos_x;
            r_out.pos_y          <= r_pos_y;
            r_out.heading_tenths <= r_prev_head;
        end
    end

    assign o_sts.head_ok  = head_ok;
    assign o_sts.is_clear = i_in_data.command;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

`ifndef NO_ASSERTIONS
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev_head <= 12'sd1800) && (r_prev_head >= -12'sd1800))
        else $error("stored heading out of range");
    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (!r_out_valid || !i_out_stall))
        else $error("result beat overwritten");
    a_clear_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_in_data.command) |=> (r_acc_x == 48'sd0 && r_acc_y == 48'sd0))
        else $error("clear did not zero accumulators");
`endif

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none
// ============================================================================
// testbench
// Checks the encoder and gyro odometry block: a local predictor tracks the
// encoder, heading and position state, directed and random beats go in with
// random gaps and stalls, and each result beat is compared with the oldest
// prediction.
// ============================================================================
module testbench;

    localparam int ACC_FB  = ego_pkg::ACC_FRAC_BITS_DEF;
    localparam int TRIG_FB = ego_pkg::TRIG_FRAC_BITS_DEF;
    localparam longint POS_MAX = 64'sd140737488355327;
    localparam longint POS_MIN = -64'sd140737488355328;
    localparam longint RAD_PER_TENTH_Q32 = 64'sd7496132;
    localparam int CYCLE_LIMIT = 600000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;
    logic      in_valid;
    logic      in_stall;
    ego_pkg::t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    ego_pkg::t_out_item out_data;

    encoder_gyro_odometry DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    // Predictor state.
    longint    ofs_x, ofs_y;
    bit        flip_x, flip_y;
    bit [31:0] last_enc_x, last_enc_y;
    int        last_head;
    longint    pos_acc_x, pos_acc_y;

    ego_pkg::t_in_item  pending_beats[$];
    ego_pkg::t_out_item expected_poses[$];
    int        mismatches;
    int        cycles;
    bit        stim_done;
    bit        drain_req;
    int        in_gap;
    int        out_gap;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint round_shift(longint v, int s);
        if (s == 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp48(longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    function automatic int wrap_heading(int h);
        while (h > 1800) h -= 3600;
        while (h < -1800) h += 3600;
        return h;
    endfunction

    function automatic longint sine_entry(int a);
        return round_shift(longint'(ego_pkg::SINE_Q15[a]), 15 - TRIG_FB);
    endfunction

    function automatic longint sin_of(int d);
        int a;
        longint s;
        a = d < 0 ? -d : d;
        s = (a <= 90) ? sine_entry(a) : sine_entry(180 - a);
        return d < 0 ? -s : s;
    endfunction

    function automatic longint cos_of(int d);
        int a;
        a = d < 0 ? -d : d;
        return (a <= 90) ? sine_entry(90 - a) : -sine_entry(a - 90);
    endfunction

    function automatic logic signed [15:0] scale_pos(longint acc);
        longint q;
        q = (acc * 3) / (64'sd20 <<< ACC_FB);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic ego_pkg::t_out_item predict_pose(ego_pkg::t_in_item it);
        ego_pkg::t_out_item r;
        bit [31:0] ex, ey;
        int        head, dh, deg;
        longint    dx, dy, cx, cy, c, s, rx, ry;
        if (it.command) begin
            pos_acc_x = 0;
            pos_acc_y = 0;
            r.pos_x = '0;
            r.pos_y = '0;
            r.heading_tenths = last_head[11:0];
            return r;
        end
        ex = flip_x ? 32'd0 - it.encoder_x : it.encoder_x;
        ey = flip_y ? 32'd0 - it.encoder_y : it.encoder_y;
        head = wrap_heading(int'(it.gyro_tenths));
        dx = longint'($signed(ex - last_enc_x));
        dy = longint'($signed(ey - last_enc_y));
        dh = wrap_heading(head - last_head);
        last_enc_x = ex;
        last_enc_y = ey;
        last_head = head;
        cx = clamp48(dx * (64'sd1 <<< ACC_FB)
             - round_shift(ofs_y * dh * RAD_PER_TENTH_Q32, 32 - ACC_FB));
        cy = clamp48(dy * (64'sd1 <<< ACC_FB)
             - round_shift(ofs_x * dh * RAD_PER_TENTH_Q32, 32 - ACC_FB));
        deg = head / 10;
        s = sin_of(deg);
        c = cos_of(deg);
        rx = round_shift(cx * c - cy * s, TRIG_FB);
        ry = round_shift(cy * c + cx * s, TRIG_FB);
        pos_acc_x = clamp48(pos_acc_x + rx);
        pos_acc_y = clamp48(pos_acc_y + ry);
        r.pos_x = scale_pos(pos_acc_x);
        r.pos_y = scale_pos(pos_acc_y);
        r.heading_tenths = head[11:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ego_pkg::CFG_OFFSET_X: ofs_x = longint'($signed(val));
            ego_pkg::CFG_OFFSET_Y: ofs_y = longint'($signed(val));
            ego_pkg::CFG_INVERT_X: flip_x = val[0];
            default:               flip_y = val[0];
        endcase
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid || expected_poses.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic ego_pkg::t_in_item make_update(logic [31:0] ex, logic [31:0] ey,
                                                      logic [15:0] g);
        ego_pkg::t_in_item it;
        it.command = 1'b0;
        it.encoder_x = ex;
        it.encoder_y = ey;
        it.gyro_tenths = g;
        return it;
    endfunction

    // Random beat: mostly small motion around the running readings, some jumps, occasional clears.
    function automatic ego_pkg::t_in_item random_beat(ref logic [31:0] ex,
                                                      ref logic [31:0] ey,
                                                      ref logic [15:0] g);
        int p;
        ego_pkg::t_in_item it;
        p = $urandom_range(0, 99);
        if (p < 4) begin
            it = make_update(ex, ey, g);
            it.command = 1'b1;
            return it;
        end
        if (p < 75) begin
            ex = ex + $signed($urandom_range(0, 4000)) - 2000;
            ey = ey + $signed($urandom_range(0, 4000)) - 2000;
            g = 16'(g + $signed($urandom_range(0, 200)) - 100);
        end else if (p < 90) begin
            ex = ex + $signed($urandom_range(0, 400000)) - 200000;
            ey = ey + $signed($urandom_range(0, 400000)) - 200000;
            g = 16'($urandom_range(0, 7200) - 3600);
        end else begin
            ex = $urandom;
            ey = $urandom;
            g = 16'($urandom);
        end
        return make_update(ex, ey, g);
    endfunction

    task automatic run_random(int n);
        logic [31:0] ex, ey;
        logic [15:0] g;
        ex = '0; ey = '0; g = '0;
        for (int k = 0; k < n; k++) pending_beats.push_back(random_beat(ex, ey, g));
    endtask

    initial begin
        ego_pkg::t_in_item it;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        stim_done = 1'b0;
        drain_req = 1'b0;
        ofs_x = -344; ofs_y = 1238; flip_x = 0; flip_y = 0;
        last_enc_x = '0; last_enc_y = '0; last_head = 0;
        pos_acc_x = 0; pos_acc_y = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: heading extremes and wrap, encoder extremes and wrap, clear.
        pending_beats.push_back(make_update(32'd100, 32'd200, 16'sd1800));
        pending_beats.push_back(make_update(32'd300, 32'd100, -16'sd1800));
        pending_beats.push_back(make_update(32'd500, 32'd400, 16'sd1801));
        pending_beats.push_back(make_update(32'd600, 32'd600, -16'sd1801));
        pending_beats.push_back(make_update(32'd700, 32'd700, 16'sd32767));
        pending_beats.push_back(make_update(32'd800, 32'd900, -16'sd32768));
        pending_beats.push_back(make_update(32'h7fffffff, 32'h80000000, 16'sd900));
        pending_beats.push_back(make_update(32'h80000000, 32'h7fffffff, -16'sd900));
        pending_beats.push_back(make_update(32'h7fffffff, 32'h7fffffff, 16'sd5));
        pending_beats.push_back(make_update(32'hffffffff, 32'h00000000, -16'sd9));
        it = make_update('0, '0, '0);
        it.command = 1'b1;
        pending_beats.push_back(it);
        pending_beats.push_back(make_update(32'd1000, 32'd1000, 16'sd450));
        pending_beats.push_back(make_update(32'd1500, 32'd1700, 16'sd1799));
        pending_beats.push_back(make_update(32'd2000, 32'd2000, -16'sd1799));
        // Swing the encoders repeatedly between full scale and zero at zero heading.
        for (int k = 0; k < 6; k++) begin
            pending_beats.push_back(make_update(32'h7fffffff, 32'h7fffffff, 16'sd0));
            pending_beats.push_back(make_update(32'h00000000, 32'h00000000, 16'sd0));
        end
        run_random(180);
        wait_idle();

        write_reg(ego_pkg::CFG_OFFSET_X, 16'h7fff);
        write_reg(ego_pkg::CFG_OFFSET_Y, 16'h8000);
        write_reg(ego_pkg::CFG_INVERT_X, 16'd1);
        write_reg(ego_pkg::CFG_INVERT_Y, 16'd0);
        pending_beats.push_back(make_update(32'h80000000, 32'd0, 16'sd1800));
        pending_beats.push_back(make_update(32'd0, 32'd0, -16'sd1800));
        run_random(200);
        // The sender holds each beat until every earlier result is through.
        drain_req = 1'b1;
        wait_idle();
        drain_req = 1'b0;

        write_reg(ego_pkg::CFG_OFFSET_X, 16'h8000);
        write_reg(ego_pkg::CFG_OFFSET_Y, 16'h7fff);
        write_reg(ego_pkg::CFG_INVERT_X, 16'd0);
        write_reg(ego_pkg::CFG_INVERT_Y, 16'd1);
        run_random(200);
        wait_idle();

        write_reg(ego_pkg::CFG_OFFSET_X, 16'($urandom));
        write_reg(ego_pkg::CFG_OFFSET_Y, 16'($urandom));
        write_reg(ego_pkg::CFG_INVERT_X, 16'd1);
        write_reg(ego_pkg::CFG_INVERT_Y, 16'd1);
        run_random(240);
        wait_idle();
        stim_done = 1'b1;
    end

    // Driver: one beat held until accepted, random gaps in between.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
            in_gap <= 0;
        end else if (in_valid && !in_stall) begin
            expected_poses.push_back(predict_pose(in_data));
            in_valid <= 1'b0;
            in_gap <= pick_gap();
        end else if (!in_valid) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
            end else if ((!drain_req || expected_poses.size() == 0) &&
                         pending_beats.size() != 0) begin
                in_data <= pending_beats.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // Monitor: compares each accepted result beat, stalls at random.
    always @(posedge clk) begin
        ego_pkg::t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b1;
            out_gap <= 0;
            mismatches <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_poses.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result beat %h", out_data);
                end else begin
                    want = expected_poses.pop_front();
                    if (want !== out_data) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp x=%0d y=%0d h=%0d got x=%0d y=%0d h=%0d",
                                     want.pos_x, want.pos_y, want.heading_tenths,
                                     out_data.pos_x, out_data.pos_y,
                                     out_data.heading_tenths);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end else begin
                out_gap <= pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        cycles = 0;
        while (!stim_done && cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        if (!stim_done) begin
            $display("CHECKS FAILED");
        end else begin
            @(posedge clk);
            if (mismatches == 0 && expected_poses.size() == 0) begin
                $display("ALL CHECKS PASSED");
            end else begin
                $display("CHECKS FAILED");
            end
        end
        $finish;
    end

endmodule
`default_nettype wire
